@@ rtl/fjvs_pkg.sv @@
package fjvs_pkg;

  // Stream widths: fields packed from bit 0, padded to whole bytes.
  localparam int IN_W  = 288;
  localparam int OUT_W = 144;

  localparam int MAX_JOINTS_DEF = 256;
  localparam int INFLUENCES     = 4;
  localparam int KW             = $clog2(INFLUENCES);

  // Restoring divider yields one quotient bit per step; square root one bit per step.
  localparam int DIV_STEPS  = 17;
  localparam int SQRT_STEPS = 32;
  localparam int CW         = 5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WDIV_LD,
    ST_WDIV_STEP,
    ST_WDIV_ST,
    ST_ROW_RD,
    ST_ROW_MUL,
    ST_ROW_ACC,
    ST_WMUL,
    ST_BLEND,
    ST_FINPOS,
    ST_MAX,
    ST_SHIFT,
    ST_SCALE,
    ST_SQMUL,
    ST_SQACC,
    ST_SQRT_LD,
    ST_SQRT_STEP,
    ST_NDIV_LD,
    ST_NDIV_STEP,
    ST_NDIV_ST,
    ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DECIDE,
    OP_DIV_W_LOAD,
    OP_DIV_STEP,
    OP_DIV_W_STORE,
    OP_RD,
    OP_MUL,
    OP_ACC_T,
    OP_ACC,
    OP_WMUL,
    OP_BLEND,
    OP_FINPOS,
    OP_MAX,
    OP_SHIFT,
    OP_SCALE,
    OP_SQMUL,
    OP_SQACC,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_DIV_N_LOAD,
    OP_DIV_N_STORE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [KW-1:0] k;   // influence
    logic [1:0]    i;   // output row / axis
    logic [1:0]    e;   // matrix element of the row: translation, then columns
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic wzero;
    logic nzero;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/fjvs_ctrl.sv @@
module fjvs_ctrl import fjvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic mode,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t        state, state_next;
  logic [KW-1:0] k, k_next;
  logic [1:0]    i, i_next;
  logic [1:0]    e, e_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      i     <= '0;
      e     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      i     <= i_next;
      e     <= e_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    e_next     = e;
    cnt_next   = cnt;
    s_tready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.k      = k;
    cmd.i      = i;
    cmd.e      = e;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_CAPTURE;
          if (mode) state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (sts.bad || sts.wzero) begin
          state_next = ST_EMIT;
        end else begin
          k_next     = '0;
          state_next = ST_WDIV_LD;
        end
      end
      ST_WDIV_LD: begin
        cmd.op     = OP_DIV_W_LOAD;
        cnt_next   = '0;
        state_next = ST_WDIV_STEP;
      end
      ST_WDIV_STEP: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) state_next = ST_WDIV_ST;
      end
      ST_WDIV_ST: begin
        cmd.op = OP_DIV_W_STORE;
        if (k == KW'(INFLUENCES - 1)) begin
          k_next     = '0;
          i_next     = '0;
          e_next     = '0;
          state_next = ST_ROW_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_WDIV_LD;
        end
      end
      ST_ROW_RD: begin
        cmd.op     = OP_RD;
        state_next = ST_ROW_MUL;
      end
      ST_ROW_MUL: begin
        cmd.op     = OP_MUL;
        state_next = ST_ROW_ACC;
      end
      ST_ROW_ACC: begin
        cmd.op = (e == 2'd0) ? OP_ACC_T : OP_ACC;
        if (e == 2'd3) begin
          e_next     = '0;
          state_next = ST_WMUL;
        end else begin
          e_next     = e + 1'b1;
          state_next = ST_ROW_RD;
        end
      end
      ST_WMUL: begin
        cmd.op     = OP_WMUL;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.op = OP_BLEND;
        if (i == 2'd2) begin
          i_next = '0;
          if (k == KW'(INFLUENCES - 1)) begin
            state_next = ST_FINPOS;
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_ROW_RD;
          end
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_ROW_RD;
        end
      end
      ST_FINPOS: begin
        cmd.op     = OP_FINPOS;
        state_next = sts.nzero ? ST_EMIT : ST_MAX;
      end
      ST_MAX: begin
        cmd.op     = OP_MAX;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts.shift_more) begin
          cmd.op = OP_SHIFT;
        end else begin
          i_next     = '0;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        if (i == 2'd2) begin
          i_next     = '0;
          state_next = ST_SQMUL;
        end else begin
          i_next = i + 1'b1;
        end
      end
      ST_SQMUL: begin
        cmd.op     = OP_SQMUL;
        state_next = ST_SQACC;
      end
      ST_SQACC: begin
        cmd.op = OP_SQACC;
        if (i == 2'd2) begin
          i_next     = '0;
          state_next = ST_SQRT_LD;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_SQMUL;
        end
      end
      ST_SQRT_LD: begin
        cmd.op     = OP_SQRT_LOAD;
        cnt_next   = '0;
        state_next = ST_SQRT_STEP;
      end
      ST_SQRT_STEP: begin
        cmd.op   = OP_SQRT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(SQRT_STEPS - 1)) begin
          i_next     = '0;
          state_next = ST_NDIV_LD;
        end
      end
      ST_NDIV_LD: begin
        cmd.op     = OP_DIV_N_LOAD;
        cnt_next   = '0;
        state_next = ST_NDIV_STEP;
      end
      ST_NDIV_STEP: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) state_next = ST_NDIV_ST;
      end
      ST_NDIV_ST: begin
        cmd.op = OP_DIV_N_STORE;
        if (i == 2'd2) begin
          i_next     = '0;
          state_next = ST_EMIT;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_NDIV_LD;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/fjvs_dp.sv @@
module fjvs_dp import fjvs_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             mode,
  input  logic             ju_we,
  input  logic [8:0]       ju_wdata,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             m_tready,
  output logic             m_tvalid,
  output logic [OUT_W-1:0] m_tdata,
  output logic [1:0]       m_tuser
);

  localparam int DEPTH = MAX_JOINTS * 16;
  localparam int AW    = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  logic [8:0]         joints_in_use;
  logic signed [31:0] pos [3];
  logic signed [15:0] nrm [3];
  logic [7:0]         jid [INFLUENCES];
  logic [15:0]        wt  [INFLUENCES];
  logic [16:0]        wn  [INFLUENCES];

  logic [47:0] rem, dvs;
  logic [16:0] quo;

  logic signed [63:0] prod_p;
  logic signed [47:0] prod_n;
  logic signed [49:0] acc_p, acc_n;
  logic signed [57:0] wp;
  logic signed [53:0] wnn;
  logic signed [59:0] p [3];
  logic signed [55:0] n [3];

  logic [55:0] mx;
  logic [5:0]  sh;
  logic        dir;
  logic [62:0] sq, xr, r, bitv;

  logic signed [31:0] res_p [3];
  logic signed [15:0] res_n [3];
  logic               res_status, res_held;

  // Combinational helpers
  logic [17:0]        wsum;
  logic               bad;
  logic [3:0]         elem;
  logic [11:0]        rfull;
  logic               mem_we;
  logic signed [31:0] pos_sel;
  logic signed [15:0] nrm_sel;
  logic signed [55:0] n_sel;
  logic [55:0]        nabs [3];
  logic [55:0]        nabs_sel;
  logic [55:0]        mxv;
  logic signed [39:0] tp;
  logic signed [35:0] tn;
  logic signed [31:0] pfin [3];
  logic signed [55:0] sdn, sup;
  logic [62:0]        sqt;
  logic [31:0]        len;
  logic signed [17:0] qs;
  logic signed [15:0] qsat;
  logic signed [31:0] mul_a, mul_b;

  localparam logic signed [49:0] TP_MAX = 50'sd549755813887;
  localparam logic signed [49:0] TP_MIN = -50'sd549755813888;

  always_comb begin
    wsum = 18'(wt[0]) + 18'(wt[1]) + 18'(wt[2]) + 18'(wt[3]);
    bad  = (joints_in_use == 9'd0) || (joints_in_use > 9'(MAX_JOINTS));
    for (int j = 0; j < INFLUENCES; j++) begin
      if ({1'b0, jid[j]} >= joints_in_use) bad = 1'b1;
    end
  end

  // Row element: translation first, then the three columns.
  always_comb begin
    if (cmd.e == 2'd0) elem = 4'd12 + 4'(cmd.i);
    else               elem = {cmd.e - 2'd1, 2'b00} + 4'(cmd.i);
    rfull = {jid[cmd.k], elem};
  end

  always_comb begin
    case (cmd.e)
      2'd1:    begin pos_sel = pos[0]; nrm_sel = nrm[0]; end
      2'd2:    begin pos_sel = pos[1]; nrm_sel = nrm[1]; end
      default: begin pos_sel = pos[2]; nrm_sel = nrm[2]; end
    endcase
    case (cmd.i)
      2'd0:    n_sel = n[0];
      2'd1:    n_sel = n[1];
      default: n_sel = n[2];
    endcase
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nabs[j] = (n[j] < 0) ? 56'(-n[j]) : 56'(n[j]);
    end
    nabs_sel = (n_sel < 0) ? 56'(-n_sel) : 56'(n_sel);
    mxv = nabs[0];
    if (nabs[1] > mxv) mxv = nabs[1];
    if (nabs[2] > mxv) mxv = nabs[2];
  end

  always_comb begin
    if (acc_p > TP_MAX)      tp = 40'(TP_MAX);
    else if (acc_p < TP_MIN) tp = 40'(TP_MIN);
    else                     tp = 40'(acc_p);
    tn = 36'((acc_n + 50'sd8192) >>> 14);
  end

  always_comb begin
    logic signed [59:0] rp;
    for (int j = 0; j < 3; j++) begin
      rp = (p[j] + 60'sd32768) >>> 16;
      if (rp > 60'sd2147483647)       pfin[j] = 32'sh7fffffff;
      else if (rp < -60'sd2147483648) pfin[j] = 32'sh80000000;
      else                            pfin[j] = 32'(rp);
    end
  end

  // Rounding right shift: floor((v + 2^(s-1)) / 2^s) done as two shifts.
  assign sdn = ((n_sel >>> (sh - 6'd1)) + 56'sd1) >>> 1;
  assign sup = n_sel <<< sh;

  assign sqt = r + bitv;
  assign len = (r == 63'd0) ? 32'd1 : 32'(r);

  always_comb begin
    qs = (n_sel < 0) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (qs > 18'sd32767)       qsat = 16'sh7fff;
    else if (qs < -18'sd32768) qsat = 16'sh8000;
    else                       qsat = 16'(qs);
  end

  // One shared 32x32 multiplier: matrix by coordinate, or a normal squared.
  always_comb begin
    if (cmd.op == OP_SQMUL) begin
      mul_a = 32'(n_sel);
      mul_b = 32'(n_sel);
    end else begin
      mul_a = $signed(rdata);
      mul_b = pos_sel;
    end
  end

  assign mem_we = (cmd.op == OP_CAPTURE) && !mode && ({1'b0, s_tdata[251:240]} < 13'(DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) mem[s_tdata[240 +: AW]] <= s_tdata[283:252];
    if (cmd.op == OP_RD) rdata <= mem[rfull[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joints_in_use <= 9'd256;
    end else if (ju_we) begin
      joints_in_use <= ju_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        if (mode) begin
          pos[0] <= s_tdata[31:0];
          pos[1] <= s_tdata[63:32];
          pos[2] <= s_tdata[95:64];
          nrm[0] <= s_tdata[111:96];
          nrm[1] <= s_tdata[127:112];
          nrm[2] <= s_tdata[143:128];
          for (int j = 0; j < INFLUENCES; j++) begin
            jid[j] <= s_tdata[144 + 8*j +: 8];
            wt[j]  <= s_tdata[176 + 16*j +: 16];
          end
        end
      end
      OP_DECIDE: begin
        res_status <= bad;
        res_held   <= !bad;
        for (int j = 0; j < 3; j++) begin
          res_p[j] <= bad ? 32'sd0 : pos[j];
          res_n[j] <= bad ? 16'sd0 : nrm[j];
          p[j]     <= '0;
          n[j]     <= '0;
        end
      end
      OP_DIV_W_LOAD: begin
        rem <= 48'({wt[cmd.k], 16'h0000}) + 48'(wsum[17:1]);
        dvs <= 48'(wsum) << 16;
        quo <= '0;
      end
      OP_DIV_N_LOAD: begin
        rem <= (48'(nabs_sel[30:0]) << 14) + 48'(len[31:1]);
        dvs <= 48'(len) << 16;
        quo <= '0;
      end
      OP_DIV_STEP: begin
        if (rem >= dvs) begin
          rem <= rem - dvs;
          quo <= {quo[15:0], 1'b1};
        end else begin
          quo <= {quo[15:0], 1'b0};
        end
        dvs <= dvs >> 1;
      end
      OP_DIV_W_STORE: wn[cmd.k] <= quo;
      OP_MUL: begin
        prod_p <= mul_a * mul_b;
        prod_n <= $signed(rdata) * nrm_sel;
      end
      OP_ACC_T: begin
        acc_p <= 50'($signed(rdata));
        acc_n <= '0;
      end
      OP_ACC: begin
        acc_p <= acc_p + 50'((prod_p + 64'sd32768) >>> 16);
        acc_n <= acc_n + 50'(prod_n);
      end
      OP_WMUL: begin
        wp  <= $signed({1'b0, wn[cmd.k]}) * tp;
        wnn <= $signed({1'b0, wn[cmd.k]}) * tn;
      end
      OP_BLEND: begin
        for (int j = 0; j < 3; j++) begin
          if (cmd.i == 2'(j)) begin
            p[j] <= p[j] + 60'(wp);
            n[j] <= n[j] + 56'(wnn);
          end
        end
      end
      OP_FINPOS: begin
        res_status <= 1'b0;
        res_held   <= 1'b0;
        for (int j = 0; j < 3; j++) begin
          res_p[j] <= pfin[j];
          res_n[j] <= nrm[j];
        end
      end
      OP_MAX: begin
        mx  <= mxv;
        dir <= (mxv >= 56'd1073741824);
        sh  <= '0;
        sq  <= '0;
      end
      OP_SHIFT: begin
        mx <= dir ? (mx >> 1) : (mx << 1);
        sh <= sh + 6'd1;
      end
      OP_SCALE: begin
        for (int j = 0; j < 3; j++) begin
          if (cmd.i == 2'(j)) n[j] <= dir ? sdn : sup;
        end
      end
      OP_SQMUL: prod_p <= mul_a * mul_b;
      OP_SQACC: sq <= sq + 63'($unsigned(prod_p));
      OP_SQRT_LOAD: begin
        xr   <= sq;
        r    <= '0;
        bitv <= 63'(1) << 62;
      end
      OP_SQRT_STEP: begin
        if (xr >= sqt) begin
          xr <= xr - sqt;
          r  <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
      end
      OP_DIV_N_STORE: begin
        for (int j = 0; j < 3; j++) begin
          if (cmd.i == 2'(j)) res_n[j] <= qsat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      m_tdata <= {res_n[2], res_n[1], res_n[0], res_p[2], res_p[1], res_p[0]};
      m_tuser <= {res_held, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    sts.bad        = bad;
    sts.wzero      = (wsum == 18'd0);
    sts.nzero      = (n[0] == 56'sd0) && (n[1] == 56'sd0) && (n[2] == 56'sd0);
    sts.shift_more = dir ? (mx >= 56'd1073741824) : (mx < 56'd536870912);
    sts.out_free   = !m_tvalid || m_tready;
  end

`ifndef SYNTH
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_W_STORE) |-> (quo <= 17'd65536))
    else $error("normalized weight exceeds one");

  a_normal_scaled: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQMUL) |-> (nabs_sel <= 56'd1073741824))
    else $error("scaled normal component out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> (!m_tvalid || m_tready))
    else $error("result overwrites an untaken beat");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("invalid and held flags both set");
`endif

endmodule

@@ rtl/four_joint_vertex_skinning.sv @@
// Four-influence linear blend skinning with a joint matrix store.
// Input stream (s_*): tuser carries the mode. A mode 0 beat writes one Q16.16
// word of a column-major joint matrix; a mode 1 beat skins one vertex and
// gives exactly one output beat. Load beats give no output.
// Output stream (m_*): skinned position, unit normal, and the invalid/held flags.
// Flow: a load beat writes one store word and the input stays ready. A vertex
// with an invalid joint index or a zero weight sum goes from the decide state
// straight to the emit state. A full vertex runs four 17-step weight divisions,
// 48 matrix words each read, multiplied and accumulated in turn, a normal
// renormalization with a shift search, a 32-step square root and three more
// 17-step divisions, on a bit-serial divider and one matrix store read port.
// One vertex is in flight at a time; the next beat is taken as soon as the
// result sits in the output register, even if the receiver has not taken it.
// A stall on m_tready holds that register and then holds the input side.
// Reset clears the handshake state and sets joints_in_use to 256; the matrix
// store is not cleared, so every entry must be loaded before it is used.
module four_joint_vertex_skinning import fjvs_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata, low bit up: pos_x[32], pos_y[32], pos_z[32], nrm_x[16], nrm_y[16],
  // nrm_z[16], joint_ids[32], weights_lo[32], weights_hi[32], matrix_addr[12],
  // matrix_word[32], zero padding[4]
  input  logic [IN_W-1:0]  s_tdata,
  // s_tuser: mode[1]
  input  logic [0:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata, low bit up: out_x[32], out_y[32], out_z[32], out_nx[16],
  // out_ny[16], out_nz[16]
  output logic [OUT_W-1:0] m_tdata,
  // m_tuser, low bit up: status[1], held[1]
  output logic [1:0]       m_tuser,
  input  logic             joints_in_use_we,
  input  logic [8:0]       joints_in_use_wdata
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences every step; the datapath owns all arithmetic,
  // the matrix store and the output register.
  fjvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser[0]),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fjvs_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .mode     (s_tuser[0]),
    .ju_we    (joints_in_use_we),
    .ju_wdata (joints_in_use_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
